### rtl/core/apsd_pkg.sv
// shared constants, types and the threshold tier table for the step detector
`timescale 1ns / 1ps

package apsd_pkg;

    // sample and magnitude widths
    localparam int AXIS_W = 16;
    localparam int TIME_W = 32;
    localparam int MAG_W  = 16;
    localparam int CNT_W  = 32;
    localparam int RUN_W  = 8;

    typedef logic [MAG_W-1:0] mag_t;

    // swing averaging window
    localparam int WIN_DEPTH  = 4;
    localparam int WIN_FILL_W = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W      = MAG_W + $clog2(WIN_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR = 2'd2;

    // register values after reset
    localparam mag_t MIN_PEAK_RST = 16'd11000;
    localparam mag_t MIN_INTV_RST = 16'd250;
    localparam mag_t INIT_THR_RST = 16'd20000;

    // rise run needed before a fall counts as a peak
    localparam logic [RUN_W-1:0] PEAK_MIN_RUN = 8'd2;
    localparam logic [RUN_W-1:0] RUN_MAX      = 8'd255;

    // threshold tiers over the window mean
    localparam logic [31:0] TIER_LIM_3 = 32'd80000;
    localparam logic [31:0] TIER_LIM_2 = 32'd60000;
    localparam logic [31:0] TIER_LIM_1 = 32'd40000;
    localparam logic [31:0] TIER_LIM_0 = 32'd20000;
    localparam mag_t        TIER_THR_4 = 16'd30000;
    localparam mag_t        TIER_THR_3 = 16'd20000;
    localparam mag_t        TIER_THR_2 = 16'd12000;
    localparam mag_t        TIER_THR_1 = 16'd8000;
    localparam mag_t        TIER_THR_0 = 16'd5000;

    // map a window mean to its swing threshold
    function automatic mag_t tier_of_mean(input logic [SUM_W-1:0] mean);
        logic [31:0] m;
        mag_t        thr;
        m = 32'(mean);
        if (m >= TIER_LIM_3)
            thr = TIER_THR_4;
        else if (m >= TIER_LIM_2)
            thr = TIER_THR_3;
        else if (m >= TIER_LIM_1)
            thr = TIER_THR_2;
        else if (m >= TIER_LIM_0)
            thr = TIER_THR_1;
        else
            thr = TIER_THR_0;
        return thr;
    endfunction

endpackage

### rtl/core/accel_peak_step_detector.sv
// step detector top level: magnitude, square root, peak and valley tracking
`timescale 1ns / 1ps

// Takes one accelerometer sample per input transaction and returns one result
// transaction per sample. A sample occupies the block from acceptance to the
// next possible acceptance: the three axes are squared and summed through one
// shared 16x16 multiplier, the square root retires two radicand bits per
// cycle, and the peak/step update and the return to idle follow. The result
// sits in an output register, so a new sample can be accepted while the last
// result waits; the update cycle holds only if that register is still full.
// Configuration writes are taken at any time but are meant for idle periods;
// a write to initial_threshold also loads the live threshold.
module accel_peak_step_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [apsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [apsd_pkg::AXIS_W-1:0] accel_x,
    input  logic signed [apsd_pkg::AXIS_W-1:0] accel_y,
    input  logic signed [apsd_pkg::AXIS_W-1:0] accel_z,
    input  logic [apsd_pkg::TIME_W-1:0]        time_ms,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               step_seen,
    output logic [apsd_pkg::CNT_W-1:0]         step_total,
    output logic [apsd_pkg::MAG_W-1:0]         swing_threshold
);
    import apsd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQR  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    localparam int          ROOT_STEPS = MAG_W;
    localparam int          RCNT_W     = $clog2(ROOT_STEPS);
    localparam int          REM_W      = MAG_W + 1;
    localparam logic [1:0]  SQ_LAST    = 2'd3;

    // control
    logic [1:0]        state_reg, state_next;
    logic [1:0]        sq_cnt_reg;
    logic [RCNT_W-1:0] root_cnt_reg;

    // datapath
    logic [3*AXIS_W-1:0] abs_sr_reg;
    logic [31:0]         prod_reg;
    logic [31:0]         acc_reg;
    logic [REM_W-1:0]    rem_reg;
    mag_t                root_reg;
    logic [TIME_W-1:0]   time_reg;

    // configuration registers
    mag_t min_peak_reg;
    mag_t min_intv_reg;

    // detector state
    mag_t                  prev_mag_reg;
    logic                  rising_reg;
    logic [RUN_W-1:0]      rise_run_reg;
    logic [RUN_W-1:0]      run_before_fall_reg;
    mag_t                  valley_reg;
    logic [TIME_W-1:0]     last_step_reg;
    mag_t                  thr_reg;
    mag_t                  window_reg [WIN_DEPTH];
    logic [SUM_W-1:0]      win_sum_reg;
    logic [WIN_FILL_W-1:0] win_fill_reg;
    logic [CNT_W-1:0]      steps_reg;

    // output register
    logic out_valid_reg;
    logic step_seen_reg;

    logic in_take;
    logic out_free;
    logic upd_fire;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign upd_fire  = (state_reg == ST_UPD) && out_free;

    assign out_valid       = out_valid_reg;
    assign step_seen       = step_seen_reg;
    assign step_total      = steps_reg;
    assign swing_threshold = thr_reg;

    // absolute values of the axes, most negative code maps to 32768
    logic [AXIS_W-1:0] abs_x, abs_y, abs_z;
    always_comb
    begin
        abs_x = accel_x[AXIS_W-1] ? AXIS_W'(-accel_x) : AXIS_W'(accel_x);
        abs_y = accel_y[AXIS_W-1] ? AXIS_W'(-accel_y) : AXIS_W'(accel_y);
        abs_z = accel_z[AXIS_W-1] ? AXIS_W'(-accel_z) : AXIS_W'(accel_z);
    end

    // one square root digit: two radicand bits in, one root bit out
    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic             trial_ok;
    always_comb
    begin
        rem_shift = {rem_reg, acc_reg[31:30]};
        trial     = {1'b0, root_reg, 2'b01};
        trial_ok  = (rem_shift >= trial);
    end

    // peak, valley and step decision for the current magnitude
    mag_t                  mag;
    logic                  rising_n;
    logic [RUN_W-1:0]      rise_run_n;
    logic [RUN_W-1:0]      rbf_n;
    logic                  peak_hit;
    logic                  valley_hit;
    mag_t                  swing;
    logic [TIME_W-1:0]     elapsed;
    logic                  step_hit;
    logic                  win_full;
    logic [SUM_W-1:0]      mean;
    always_comb
    begin
        mag        = root_reg;
        rising_n   = (mag >= prev_mag_reg);
        rise_run_n = rising_n ? ((rise_run_reg < RUN_MAX) ? rise_run_reg + 1'b1 : rise_run_reg)
                              : '0;
        rbf_n      = rising_n ? run_before_fall_reg : rise_run_reg;
        peak_hit   = (prev_mag_reg != '0) && !rising_n && rising_reg &&
                     (rbf_n >= PEAK_MIN_RUN) && (prev_mag_reg >= min_peak_reg);
        valley_hit = (prev_mag_reg != '0) && !peak_hit && !rising_reg && rising_n;
        swing      = (prev_mag_reg > valley_reg) ? mag_t'(prev_mag_reg - valley_reg) : '0;
        elapsed    = time_reg - last_step_reg;
        step_hit   = peak_hit && (elapsed >= TIME_W'(min_intv_reg)) && (swing >= thr_reg);
        win_full   = (win_fill_reg == WIN_FILL_W'(WIN_DEPTH));
        mean       = SUM_W'(win_sum_reg / WIN_DEPTH);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_SQR;
            ST_SQR:  if (sq_cnt_reg == SQ_LAST) state_next = ST_ROOT;
            ST_ROOT: if (root_cnt_reg == RCNT_W'(ROOT_STEPS - 1)) state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sq_cnt_reg   <= '0;
            root_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_take)
                sq_cnt_reg <= '0;
            else if (state_reg == ST_SQR)
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            if (state_reg == ST_SQR)
                root_cnt_reg <= '0;
            else if (state_reg == ST_ROOT)
                root_cnt_reg <= root_cnt_reg + 1'b1;
        end
    end

    // squaring and square root datapath
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            abs_sr_reg <= {abs_z, abs_y, abs_x};
            acc_reg    <= '0;
            time_reg   <= time_ms;
        end
        else if (state_reg == ST_SQR)
        begin
            // axis squares one per cycle, each summed in the next cycle, modulo 2^32
            if (sq_cnt_reg != SQ_LAST)
            begin
                prod_reg   <= abs_sr_reg[AXIS_W-1:0] * abs_sr_reg[AXIS_W-1:0];
                abs_sr_reg <= abs_sr_reg >> AXIS_W;
            end
            if (sq_cnt_reg != '0)
                acc_reg <= acc_reg + prod_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_ROOT)
        begin
            acc_reg <= acc_reg << 2;
            if (trial_ok)
            begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_shift);
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    // configuration and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_peak_reg        <= MIN_PEAK_RST;
            min_intv_reg        <= MIN_INTV_RST;
            thr_reg             <= INIT_THR_RST;
            prev_mag_reg        <= '0;
            rising_reg          <= 1'b0;
            rise_run_reg        <= '0;
            run_before_fall_reg <= '0;
            valley_reg          <= '0;
            last_step_reg       <= '0;
            win_sum_reg         <= '0;
            win_fill_reg        <= '0;
            steps_reg           <= '0;
            step_seen_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_MIN_PEAK: min_peak_reg <= cfg_data;
                    CFG_MIN_INTV: min_intv_reg <= cfg_data;
                    default: ;
                endcase
            end
            // live threshold: tier from the mean before the new swing enters,
            // else a write to initial_threshold
            if (upd_fire && step_hit && win_full)
                thr_reg <= tier_of_mean(mean);
            else if (cfg_wr_en && (cfg_index == CFG_INIT_THR))
                thr_reg <= cfg_data;
            if (upd_fire)
            begin
                prev_mag_reg  <= mag;
                step_seen_reg <= step_hit;
                if (prev_mag_reg != '0)
                begin
                    rising_reg          <= rising_n;
                    rise_run_reg        <= rise_run_n;
                    run_before_fall_reg <= rbf_n;
                end
                if (valley_hit)
                    valley_reg <= prev_mag_reg;
                if (step_hit)
                begin
                    last_step_reg <= time_reg;
                    steps_reg     <= steps_reg + 1'b1;
                    if (!win_full)
                    begin
                        win_fill_reg <= win_fill_reg + 1'b1;
                        win_sum_reg  <= win_sum_reg + SUM_W'(swing);
                    end
                    else
                    begin
                        win_sum_reg <= win_sum_reg - SUM_W'(window_reg[0]) + SUM_W'(swing);
                    end
                end
            end
        end
    end

    // swing window, oldest entry at index zero
    always_ff @(posedge clk)
    begin
        if (upd_fire && step_hit)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
                window_reg[i] <= window_reg[i+1];
            window_reg[WIN_DEPTH-1] <= swing;
        end
    end

    // output transaction handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (upd_fire)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    // checks
    a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside the update cycle");

    a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && step_hit) |=> (steps_reg == $past(steps_reg) + 1'b1) && step_seen_reg)
        else $error("accepted step not counted");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_fill_reg <= WIN_FILL_W'(WIN_DEPTH))
        else $error("window fill beyond depth");

    a_run_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (rise_run_reg != '0) |-> rising_reg)
        else $error("rise run set while falling");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |=> (state_reg == ST_ROOT) || (state_reg == ST_UPD))
        else $error("root iteration left early");

endmodule
